// ----- hw/rtl/pfb_pkg.sv -----
package pfb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;
   localparam int ROW_DEPTH         = 128;
   localparam int COL_W             = 7;
   localparam int PAGE_W            = 3;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X      = 2'd0,
      REG_DEST_Y      = 2'd1,
      REG_IMAGE_WIDTH = 2'd2,
      REG_IMAGE_PAGES = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] byte_data;
      logic [7:0] col;
      logic [3:0] page;
      logic       first_row;
      logic       last_row;
      logic       fits;
      logic [2:0] yoff;
   } stage_type;

   typedef struct packed {
      logic [9:0] fb_address;
      logic [7:0] fb_data;
      logic       write_enable;
      logic       last_of_item;
   } result_type;

endpackage

// ----- hw/rtl/pfb_req_if.sv -----
interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] image_byte;
   logic       start_of_image;

   modport source (output valid, image_byte, start_of_image, input ready);
   modport sink (input valid, image_byte, start_of_image, output ready);
endinterface

// ----- hw/rtl/pfb_rsp_if.sv -----
interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] fb_address;
   logic [7:0] fb_data;
   logic       write_enable;
   logic       last_of_item;

   modport source (output valid, fb_address, fb_data, write_enable, last_of_item, input ready);
   modport sink (input valid, fb_address, fb_data, write_enable, last_of_item, output ready);
endinterface

// ----- hw/rtl/pfb_merge.sv -----
module pfb_merge #(
   parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
   input  pfb_pkg::stage_type  stage,
   input  logic                sel,
   input  logic [7:0]          row_data,
   output pfb_pkg::result_type result,
   output logic                two_results
);

   localparam logic [8:0]  SW_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [4:0]  PR_LIM  = 5'(SCREEN_HEIGHT / 8);
   localparam logic [12:0] SW_MULT = 13'(SCREEN_WIDTH);

   logic        aligned;
   logic [4:0]  page;
   logic [3:0]  rsh;
   logic [7:0]  shl;
   logic [7:0]  row_hi;
   logic [7:0]  byte_hi;
   logic [7:0]  data;
   logic        allow;
   logic        on_screen;
   logic        we;
   logic [12:0] addr_full;

   always_comb begin
      aligned   = (stage.yoff == 3'd0);
      page      = {1'b0, stage.page} + {4'd0, sel};
      rsh       = 4'd8 - {1'b0, stage.yoff};
      shl       = stage.byte_data << stage.yoff;
      row_hi    = row_data >> rsh;
      byte_hi   = stage.byte_data >> rsh;
      if (aligned) begin
         data = stage.byte_data;
      end else if (sel) begin
         data = byte_hi;
      end else begin
         data = shl | (stage.first_row ? 8'd0 : row_hi);
      end
      allow     = aligned ? stage.fits : 1'b1;
      on_screen = ({1'b0, stage.col} < SW_LIM) && (page < PR_LIM);
      we        = allow && on_screen;
      addr_full = 13'(page) * SW_MULT + 13'(stage.col);

      result.fb_address   = we ? addr_full[9:0] : 10'd0;
      result.fb_data      = we ? data : 8'd0;
      result.write_enable = we;
      result.last_of_item = aligned || sel || !stage.last_row;
      two_results         = !aligned && stage.last_row;
   end

endmodule

// ----- hw/rtl/page_framebuffer_image_blit.sv -----
// Page-mode monochrome image blit.
// Input channel req: one image byte per transfer (a vertical 8-pixel slice,
// bit 0 on top), column by column inside each page row, rows top to bottom.
// start_of_image restarts the column and page counters.
// Output channel rsp: framebuffer overwrite accesses, one per transfer. A byte
// gives one access, or two on the last page row of an image whose dest_y is
// not a multiple of 8 (shifted byte, then the spill byte one page below).
// last_of_item marks the final access of each byte.
// csr port: dest_x, dest_y, image_width, image_pages by index; write only
// while the block is idle.
// The first access of a byte passes the input stage register and then the
// output register. The block takes one byte per cycle while the receiver
// does not stall; a two-access byte holds the input stage until both are out.
// Reset (synchronous) clears the counters, the fit flag and both stages and
// loads the registers with their defaults; the row buffer is not cleared.
// A stalled receiver holds the output register; the block keeps one more
// byte in its input stage and then drops req.ready.
module page_framebuffer_image_blit #(
   parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pfb_req_if.sink                          req,
   pfb_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [pfb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [8:0] SW_LIM = 9'(SCREEN_WIDTH);
   localparam logic [7:0] SH_LIM = 8'(SCREEN_HEIGHT);

   logic [6:0] dest_x_ff;
   logic [5:0] dest_y_ff;
   logic [7:0] image_width_ff;
   logic [3:0] image_pages_ff;

   logic [pfb_pkg::COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [pfb_pkg::PAGE_W-1:0] page_cnt_ff, page_cnt_in;
   logic                       fits_ff, fits_in;

   logic                s1_vld_ff, s1_vld_in;
   logic                sel_ff, sel_in;
   pfb_pkg::stage_type  stage_ff, stage_in;
   logic [7:0]          row_rd_ff;
   logic [7:0]          row_mem [pfb_pkg::ROW_DEPTH];

   logic                rsp_vld_ff, rsp_vld_in;
   pfb_pkg::result_type rsp_data_ff;
   pfb_pkg::result_type result;
   logic                two_results;

   logic [7:0]                 w_eff;
   logic [3:0]                 pages_eff;
   logic [pfb_pkg::COL_W-1:0]  c_cur;
   logic [pfb_pkg::PAGE_W-1:0] p_cur;
   logic [7:0]                 c_inc;
   logic [3:0]                 p_inc;
   logic                       fits_calc;
   logic                       out_load;
   logic                       emit;
   logic                       s1_done;
   logic                       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff      <= 7'd0;
         dest_y_ff      <= 6'd0;
         image_width_ff <= 8'd1;
         image_pages_ff <= 4'd1;
      end else if (csr_we) begin
         case (pfb_pkg::csr_reg_type'(csr_index))
            pfb_pkg::REG_DEST_X:      dest_x_ff      <= csr_wdata[6:0];
            pfb_pkg::REG_DEST_Y:      dest_y_ff      <= csr_wdata[5:0];
            pfb_pkg::REG_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            pfb_pkg::REG_IMAGE_PAGES: image_pages_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (image_width_ff == 8'd0) begin
         w_eff = 8'd1;
      end else if (image_width_ff > 8'd128) begin
         w_eff = 8'd128;
      end else begin
         w_eff = image_width_ff;
      end
      if (image_pages_ff == 4'd0) begin
         pages_eff = 4'd1;
      end else if (image_pages_ff > 4'd8) begin
         pages_eff = 4'd8;
      end else begin
         pages_eff = image_pages_ff;
      end

      c_cur = req.start_of_image ? '0 : col_cnt_ff;
      p_cur = req.start_of_image ? '0 : page_cnt_ff;
      c_inc = {1'b0, c_cur} + 8'd1;
      p_inc = {1'b0, p_cur} + 4'd1;

      fits_calc = (({2'b0, dest_x_ff} + {1'b0, w_eff}) <= SW_LIM) &&
                  (({2'b0, dest_y_ff} + {1'b0, pages_eff, 3'b000}) <= SH_LIM);
      fits_in   = ((c_cur == '0) && (p_cur == '0)) ? fits_calc : fits_ff;

      if (c_inc >= w_eff) begin
         col_cnt_in  = '0;
         page_cnt_in = (p_inc >= pages_eff) ? '0 : p_inc[pfb_pkg::PAGE_W-1:0];
      end else begin
         col_cnt_in  = c_inc[pfb_pkg::COL_W-1:0];
         page_cnt_in = p_cur;
      end

      stage_in.byte_data = req.image_byte;
      stage_in.col       = {1'b0, dest_x_ff} + {1'b0, c_cur};
      stage_in.page      = {1'b0, dest_y_ff[5:3]} + {1'b0, p_cur};
      stage_in.first_row = (p_cur == '0);
      stage_in.last_row  = (p_inc >= pages_eff);
      stage_in.fits      = fits_in;
      stage_in.yoff      = dest_y_ff[2:0];
   end

   pfb_merge #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_merge (
      .stage       (stage_ff),
      .sel         (sel_ff),
      .row_data    (row_rd_ff),
      .result      (result),
      .two_results (two_results)
   );

   always_comb begin
      out_load   = !rsp_vld_ff || rsp.ready;
      emit       = s1_vld_ff && out_load;
      s1_done    = emit && (sel_ff || !two_results);
      req.ready  = !s1_vld_ff || s1_done;
      accept     = req.valid && req.ready;
      s1_vld_in  = accept || (s1_vld_ff && !s1_done);
      sel_in     = (accept || s1_done) ? 1'b0 : (emit ? 1'b1 : sel_ff);
      rsp_vld_in = emit || (rsp_vld_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         page_cnt_ff <= '0;
         fits_ff     <= 1'b0;
         s1_vld_ff   <= 1'b0;
         sel_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (accept) begin
            col_cnt_ff  <= col_cnt_in;
            page_cnt_ff <= page_cnt_in;
            fits_ff     <= fits_in;
         end
         s1_vld_ff  <= s1_vld_in;
         sel_ff     <= sel_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff         <= stage_in;
         row_rd_ff        <= row_mem[c_cur];
         row_mem[c_cur]   <= req.image_byte;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.fb_address   = rsp_data_ff.fb_address;
   assign rsp.fb_data      = rsp_data_ff.fb_data;
   assign rsp.write_enable = rsp_data_ff.write_enable;
   assign rsp.last_of_item = rsp_data_ff.last_of_item;

endmodule

// ----- hw/rtl/pfb_checker.sv -----
module pfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [9:0] rsp_fb_address,
   input logic [7:0] rsp_fb_data,
   input logic       rsp_write_enable,
   input logic       rsp_last_of_item
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_suppressed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> (rsp_fb_address == 10'd0) && (rsp_fb_data == 8'd0))
      else $error("suppressed access carries address or data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_fb_address) && $stable(rsp_fb_data) &&
                                  $stable(rsp_write_enable) && $stable(rsp_last_of_item))
      else $error("rsp payload changed while stalled");

   a_pair_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> !req_ready || !req_valid || rsp_valid)
      else $error("first access of a pair not followed by its partner");

endmodule

bind page_framebuffer_image_blit pfb_checker u_pfb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_fb_address   (rsp.fb_address),
   .rsp_fb_data      (rsp.fb_data),
   .rsp_write_enable (rsp.write_enable),
   .rsp_last_of_item (rsp.last_of_item)
);

// ----- tb/page_framebuffer_image_blit_tb.sv -----
module page_framebuffer_image_blit_tb;

   class blit_scoreboard;
      bit [6:0]            dest_x;
      bit [5:0]            dest_y;
      bit [7:0]            width_reg;
      bit [3:0]            pages_reg;
      bit [6:0]            column_count;
      bit [2:0]            page_count;
      bit [7:0]            row_bytes [128];
      bit                  image_fits;
      pfb_pkg::result_type pending_accesses[$];
      int                  errors;
      int                  bytes_in;
      int                  accesses_out;
      int                  suppressed;
      int                  spills;
      int                  settings;

      function new();
         dest_x = 0;
         dest_y = 0;
         width_reg = 1;
         pages_reg = 1;
         column_count = 0;
         page_count = 0;
         image_fits = 0;
         foreach (row_bytes[i]) row_bytes[i] = '0;
         errors = 0;
         bytes_in = 0;
         accesses_out = 0;
         suppressed = 0;
         spills = 0;
         settings = 0;
      endfunction

      function void set_reg(pfb_pkg::csr_reg_type idx, bit [7:0] value);
         case (idx)
            pfb_pkg::REG_DEST_X: begin
               dest_x = value[6:0];
            end
            pfb_pkg::REG_DEST_Y: begin
               dest_y = value[5:0];
            end
            pfb_pkg::REG_IMAGE_WIDTH: begin
               width_reg = value;
            end
            pfb_pkg::REG_IMAGE_PAGES: begin
               pages_reg = value[3:0];
            end
            default: ;
         endcase
      endfunction

      function void push_access(int page, int col, bit [7:0] data, bit allow, bit last);
         pfb_pkg::result_type acc;
         int                  addr;
         bit                  we;
         we = allow && (col < pfb_pkg::SCREEN_WIDTH_DEF) &&
              (page < pfb_pkg::SCREEN_HEIGHT_DEF / 8);
         addr = page * pfb_pkg::SCREEN_WIDTH_DEF + col;
         acc.write_enable = we;
         acc.fb_address = we ? addr[9:0] : 10'd0;
         acc.fb_data = we ? data : 8'd0;
         acc.last_of_item = last;
         if (!we) suppressed++;
         pending_accesses.push_back(acc);
      endfunction

      function void note_byte(bit [7:0] b, bit sof);
         int       w;
         int       pages;
         int       yoff;
         int       page0;
         int       c;
         int       p;
         int       col;
         bit [7:0] merged;
         bit       last_row;
         w = width_reg;
         if (w == 0) w = 1;
         if (w > 128) w = 128;
         pages = pages_reg;
         if (pages == 0) pages = 1;
         if (pages > 8) pages = 8;
         yoff = dest_y % 8;
         page0 = dest_y / 8;
         if (sof) begin
            column_count = 0;
            page_count = 0;
         end
         if (column_count == 0 && page_count == 0) begin
            image_fits = (dest_x + w <= pfb_pkg::SCREEN_WIDTH_DEF) &&
                         (dest_y + pages * 8 <= pfb_pkg::SCREEN_HEIGHT_DEF);
         end
         c = column_count;
         p = page_count;
         col = dest_x + c;
         if (yoff == 0) begin
            push_access(page0 + p, col, b, image_fits, 1'b1);
         end else begin
            merged = b << yoff;
            last_row = (p + 1 >= pages);
            if (p > 0) merged = merged | (row_bytes[c] >> (8 - yoff));
            push_access(page0 + p, col, merged, 1'b1, !last_row);
            if (last_row) begin
               push_access(page0 + p + 1, col, b >> (8 - yoff), 1'b1, 1'b1);
               spills++;
            end
         end
         row_bytes[c] = b;
         if (c + 1 >= w) begin
            column_count = 0;
            page_count = (p + 1 >= pages) ? 3'd0 : 3'(p + 1);
         end else begin
            column_count = 7'(c + 1);
         end
         bytes_in++;
      endfunction

      task report_error(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_access(pfb_pkg::result_type got);
         pfb_pkg::result_type want;
         accesses_out++;
         if (pending_accesses.size() == 0) begin
            report_error($sformatf("unexpected access addr=%0d data=%h we=%b last=%b",
                                   got.fb_address, got.fb_data, got.write_enable,
                                   got.last_of_item));
            return;
         end
         want = pending_accesses.pop_front();
         if (got.fb_address !== want.fb_address)
            report_error($sformatf("access %0d fb_address got %0d want %0d",
                                   accesses_out, got.fb_address, want.fb_address));
         if (got.fb_data !== want.fb_data)
            report_error($sformatf("access %0d fb_data got %h want %h",
                                   accesses_out, got.fb_data, want.fb_data));
         if (got.write_enable !== want.write_enable)
            report_error($sformatf("access %0d write_enable got %b want %b",
                                   accesses_out, got.write_enable, want.write_enable));
         if (got.last_of_item !== want.last_of_item)
            report_error($sformatf("access %0d last_of_item got %b want %b",
                                   accesses_out, got.last_of_item, want.last_of_item));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [pfb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pfb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pfb_req_if req_bus ();
   pfb_rsp_if rsp_bus ();

   page_framebuffer_image_blit uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   blit_scoreboard tracker = new();

   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin : watch_channels
      pfb_pkg::result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_byte(req_bus.image_byte, req_bus.start_of_image);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.fb_address = rsp_bus.fb_address;
            got.fb_data = rsp_bus.fb_data;
            got.write_enable = rsp_bus.write_enable;
            got.last_of_item = rsp_bus.last_of_item;
            tracker.check_access(got);
         end
      end
   end

   // receiver: rotate between no stalls, short stalls, long stalls and choppy
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         case (cycle_count[9:8])
            2'd1: begin
               if ($urandom_range(3) == 0) stall_left = $urandom_range(3, 1);
            end
            2'd2: begin
               if ($urandom_range(15) == 0) stall_left = $urandom_range(15, 5);
            end
            2'd3: begin
               if ($urandom_range(1) == 0) stall_left = $urandom_range(2, 1);
            end
            default: ;
         endcase
      end
      cycle_count++;
   end

   task send_byte(bit [7:0] b, bit sof);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(30, 1);
         gap = gaps_on ? $urandom_range(12, 1) : 0;
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.image_byte <= b;
      req_bus.start_of_image <= sof;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task send_image(bit sof, int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         send_byte(8'($urandom_range(255)), (i == 0) ? sof : 1'b0);
      end
   endtask

   task wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_accesses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(pfb_pkg::csr_reg_type idx, bit [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task apply_settings(bit [7:0] x, bit [7:0] y, bit [7:0] w, bit [7:0] p);
      write_reg(pfb_pkg::REG_DEST_X, x);
      write_reg(pfb_pkg::REG_DEST_Y, y);
      write_reg(pfb_pkg::REG_IMAGE_WIDTH, w);
      write_reg(pfb_pkg::REG_IMAGE_PAGES, p);
      tracker.settings++;
   endtask

   initial begin
      #2_000_000;
      $display("timeout with %0d accesses outstanding", tracker.pending_accesses.size());
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int       eff_w;
      int       eff_pages;
      int       image_bytes;
      int       n_images;
      int       kind;
      bit [7:0] x;
      bit [7:0] y;
      bit [7:0] w;
      bit [7:0] p;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.image_byte <= '0;
      req_bus.start_of_image <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= pfb_pkg::REG_DEST_X;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // aligned, fits, counters wrap past the end of a one-byte image
      apply_settings(8'd0, 8'd0, 8'd1, 8'd1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      wait_drained();
      // aligned, too wide: rejected whole
      apply_settings(8'd126, 8'd0, 8'd4, 8'd1);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      wait_drained();
      // unaligned merge with the row above, then spill
      apply_settings(8'd0, 8'd3, 8'd2, 8'd2);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hC3, 1'b0);
      wait_drained();
      // off-screen column and spill below the screen
      apply_settings(8'd127, 8'd61, 8'd2, 8'd1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h81, 1'b0);
      wait_drained();
      // zero width and zero pages count as one
      apply_settings(8'd5, 8'd7, 8'd0, 8'd0);
      send_byte(8'hFE, 1'b1);
      send_byte(8'h7F, 1'b0);
      wait_drained();
      // oversize width and pages clamp, upper register bits drop, restart mid-image
      apply_settings(8'h80, 8'hC0, 8'd255, 8'hFF);
      send_byte(8'h55, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
      send_byte(8'h3C, 1'b0);
      wait_drained();
      // aligned, too tall: rejected whole
      apply_settings(8'd0, 8'd56, 8'd1, 8'd2);
      send_byte(8'h99, 1'b1);
      send_byte(8'h66, 1'b0);
      wait_drained();

      while (tracker.bytes_in < 1740) begin
         case ($urandom_range(15))
            0: w = 8'd0;
            1: w = 8'd128;
            2: w = 8'($urandom_range(255, 129));
            3: w = 8'($urandom_range(64, 9));
            default: w = 8'($urandom_range(8, 1));
         endcase
         eff_w = (w == 0) ? 1 : (w > 128) ? 128 : w;
         case ($urandom_range(11))
            0: p = 8'd0;
            1: p = 8'($urandom_range(15, 9));
            2: p = 8'($urandom_range(255));
            default: p = 8'($urandom_range(8, 1));
         endcase
         if (eff_w > 32) p = 8'($urandom_range(2));
         eff_pages = (p[3:0] == 0) ? 1 : (p[3:0] > 8) ? 8 : p[3:0];
         case ($urandom_range(7))
            0: x = 8'd0;
            1: x = 8'd127;
            2: x = 8'($urandom_range(255));
            3: x = 8'(128 - eff_w);
            4: x = 8'(129 - eff_w);
            default: x = 8'($urandom_range(127));
         endcase
         case ($urandom_range(9))
            0, 1, 2: y = 8'($urandom_range(7) * 8);
            3: y = 8'(64 - eff_pages * 8);
            4: y = 8'd63;
            5: y = 8'($urandom_range(255));
            default: y = 8'($urandom_range(63));
         endcase
         apply_settings(x, y, w, p);
         gaps_on = ($urandom_range(4) != 0);
         n_images = $urandom_range(4, 1);
         image_bytes = eff_w * eff_pages;
         for (int k = 0; k < n_images; k++) begin
            kind = $urandom_range(19);
            if (kind == 0)
               send_byte(8'($urandom_range(255)), (k == 0) ? 1'b1 : 1'($urandom_range(1)));
            else if (kind <= 2)
               send_image(1'b1, $urandom_range(image_bytes, 1));
            else
               send_image((k == 0) ? 1'b1 : 1'($urandom_range(3) != 0), image_bytes);
            if ($urandom_range(7) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (tracker.pending_accesses.size() != 0)
         tracker.report_error($sformatf("%0d accesses never arrived",
                                        tracker.pending_accesses.size()));
      $display("streamed %0d image bytes over %0d register settings;", tracker.bytes_in,
               tracker.settings);
      $display("checked %0d accesses, %0d suppressed, %0d spill", tracker.accesses_out,
               tracker.suppressed, tracker.spills);
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
